[hdl/pdmr_pkg.sv]
// shared types and constants of the pcm downmix resampler
package pdmr_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int MONO_W      = 16;
   localparam int RATE_W      = 18;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   localparam int OUTPUT_RATE_DEFAULT = 16000;
   localparam int MIN_NATIVE_RATE     = 8000;
   localparam int MAX_NATIVE_RATE     = 192000;
   localparam int CMD_DEPTH_DEFAULT   = 2;
   localparam int OUT_DEPTH_DEFAULT   = 8;

   localparam logic [RATE_W-1:0] NATIVE_RATE_RESET = 18'd16000;

   localparam int S16_MIN = -32768;
   localparam int S16_MAX = 32767;

   localparam logic [CSR_INDEX_W-1:0] CSR_NATIVE_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT      = 2'd2;

   localparam logic FORMAT_S16 = 1'b0;
   localparam logic FORMAT_S24 = 1'b1;

   typedef enum logic [1:0] {
      KIND_ERROR,
      KIND_PASS,
      KIND_SAMPLE
   } pdmr_kind_type;

   typedef struct packed {
      pdmr_kind_type             kind;
      logic signed [MONO_W-1:0]  sample;
   } pdmr_cmd_type;

   typedef struct packed {
      logic valid;
      logic direct;
      logic err;
      logic last;
   } pdmr_ctl_type;

   typedef struct packed {
      logic signed [MONO_W-1:0]  sample;
      logic                      err;
      logic                      last;
   } pdmr_result_type;

endpackage

[hdl/pcm_downmix_linear_resampler.sv]
// top level of the pcm downmix and linear-interpolation resampler
//
// Takes one native pcm frame per request (mono or stereo, s16 or s24), checks
// it against its format range, downmixes it to one 16-bit channel and resamples
// the stream to OUTPUT_RATE_HZ by linear interpolation with an exact phase.
// A frame outside its range gives one result with range_error set and is
// dropped. Each request gives zero, one or two results; last marks the final
// one. Requests enter a two-entry queue in the cycle they arrive; the back part
// issues one result per cycle while the result queue has credit, and a request
// that gives no result still takes an issue slot of its own. That single issue
// slot of the back sequencer sets the sustained rate. The arithmetic behind it
// is a four-stage pipeline, and each result waits in an eight-entry result
// queue. Configuration is written through the csr port while idle: the user is
// bound to this, and the block itself does not enforce it. There is no clearing
// pass after reset.
module pcm_downmix_linear_resampler #(
   parameter int OUTPUT_RATE_HZ = pdmr_pkg::OUTPUT_RATE_DEFAULT,
   parameter int CMD_DEPTH      = pdmr_pkg::CMD_DEPTH_DEFAULT,
   parameter int OUT_DEPTH      = pdmr_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request side
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [pdmr_pkg::SAMPLE_W-1:0] req_left_sample,
   input  logic signed [pdmr_pkg::SAMPLE_W-1:0] req_right_sample,
   // result side
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [pdmr_pkg::MONO_W-1:0]   rsp_out_sample,
   output logic                                 rsp_range_error,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 csr_write_en,
   input  logic [pdmr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pdmr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import pdmr_pkg::*;

   localparam int FRAC_W = $clog2(OUTPUT_RATE_HZ);

   // configuration registers
   logic [RATE_W-1:0] native_rate_ff, native_rate_in;
   logic              stereo_ff, stereo_in;
   logic              format_ff, format_in;

   // front to queue
   pdmr_cmd_type      front_cmd;
   logic [$bits(pdmr_cmd_type)-1:0] cmd_rdata;
   pdmr_cmd_type      cmd_head;
   logic              cmd_empty, cmd_pop;

   // back to pipeline
   pdmr_ctl_type             issue_ctl;
   logic signed [MONO_W-1:0] issue_a;
   logic signed [MONO_W:0]   issue_diff;
   logic [FRAC_W-1:0]        issue_frac;

   // pipeline to result queue
   logic                     out_push;
   pdmr_result_type          out_result;
   logic [$bits(pdmr_result_type)-1:0] rsp_rdata;
   pdmr_result_type          rsp_head;
   logic                     rsp_taken;

   // register writes, unknown indexes are ignored
   always_comb begin
      native_rate_in = native_rate_ff;
      stereo_in      = stereo_ff;
      format_in      = format_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_NATIVE_RATE: native_rate_in = csr_wdata[RATE_W-1:0];
            CSR_STEREO:      stereo_in      = csr_wdata[0];
            CSR_FORMAT:      format_in      = csr_wdata[0];
            default: begin
               native_rate_in = native_rate_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         native_rate_ff <= NATIVE_RATE_RESET;
         stereo_ff      <= 1'b0;
         format_ff      <= FORMAT_S16;
      end else begin
         native_rate_ff <= native_rate_in;
         stereo_ff      <= stereo_in;
         format_ff      <= format_in;
      end
   end

   // classify each request as it arrives
   pdmr_front #(
      .OUTPUT_RATE_HZ (OUTPUT_RATE_HZ)
   ) u_front (
      .native_rate_hz (native_rate_ff),
      .stereo         (stereo_ff),
      .sample_format  (format_ff),
      .left_sample    (req_left_sample),
      .right_sample   (req_right_sample),
      .cmd            (front_cmd)
   );

   // short queue that decouples intake from the sequencer
   pdmr_fifo #(
      .WIDTH (($bits(pdmr_cmd_type))),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_cmd),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .full  (req_full),
      .empty (cmd_empty)
   );

   assign cmd_head = cmd_rdata;

   // phase tracking and issue of one result per cycle while result credit remains
   pdmr_back #(
      .OUTPUT_RATE_HZ (OUTPUT_RATE_HZ),
      .OUT_DEPTH      (OUT_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .native_rate_hz (native_rate_ff),
      .cmd_empty      (cmd_empty),
      .cmd            (cmd_head),
      .cmd_pop        (cmd_pop),
      .out_pop        (rsp_taken),
      .issue_ctl      (issue_ctl),
      .issue_a        (issue_a),
      .issue_diff     (issue_diff),
      .issue_frac     (issue_frac)
   );

   // interpolation, rounding and clamp
   pdmr_interp #(
      .OUTPUT_RATE_HZ (OUTPUT_RATE_HZ)
   ) u_interp (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (issue_ctl),
      .in_a       (issue_a),
      .in_diff    (issue_diff),
      .in_frac    (issue_frac),
      .out_push   (out_push),
      .out_result (out_result)
   );

   // result queue, never overfills thanks to the back part's credits
   pdmr_fifo #(
      .WIDTH (($bits(pdmr_result_type))),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_result),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .full  (),
      .empty (rsp_empty)
   );

   assign rsp_head        = rsp_rdata;
   assign rsp_taken       = rsp_pop && !rsp_empty;
   assign rsp_out_sample  = rsp_head.sample;
   assign rsp_range_error = rsp_head.err;
   assign rsp_last        = rsp_head.last;

endmodule

[hdl/pdmr_fifo.sv]
// small flop-based first-in first-out queue
module pdmr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push_ok, pop_ok;

   assign full    = (count_ff == COUNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + COUNT_W'(push_ok) - COUNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[hdl/pdmr_front.sv]
// front part: range check, widening, downmix and request classification
module pdmr_front #(
   parameter int OUTPUT_RATE_HZ = pdmr_pkg::OUTPUT_RATE_DEFAULT
) (
   input  logic [pdmr_pkg::RATE_W-1:0]          native_rate_hz,
   input  logic                                 stereo,
   input  logic                                 sample_format,
   input  logic signed [pdmr_pkg::SAMPLE_W-1:0] left_sample,
   input  logic signed [pdmr_pkg::SAMPLE_W-1:0] right_sample,
   output pdmr_pkg::pdmr_cmd_type               cmd
);

   import pdmr_pkg::*;

   localparam logic [RATE_W-1:0]          OUT_RATE = RATE_W'(OUTPUT_RATE_HZ);
   localparam logic signed [SAMPLE_W-1:0] S16_LO   = SAMPLE_W'(S16_MIN);
   localparam logic signed [SAMPLE_W-1:0] S16_HI   = SAMPLE_W'(S16_MAX);

   logic                       left_bad, right_bad, bad;
   logic signed [SAMPLE_W-1:0] wide_l, wide_r, mono24;
   logic signed [SAMPLE_W:0]   sum, sum_adj;

   always_comb begin
      left_bad  = (left_sample < S16_LO) || (left_sample > S16_HI);
      right_bad = (right_sample < S16_LO) || (right_sample > S16_HI);
      bad       = (sample_format == FORMAT_S16) && (left_bad || (stereo && right_bad));

      if (sample_format == FORMAT_S24) begin
         wide_l = left_sample;
         wide_r = right_sample;
      end else begin
         wide_l = {left_sample[SAMPLE_W-9:0], 8'h00};
         wide_r = {right_sample[SAMPLE_W-9:0], 8'h00};
      end

      // average rounds toward zero: bump negative sums by one before the shift
      sum     = {wide_l[SAMPLE_W-1], wide_l} + {wide_r[SAMPLE_W-1], wide_r};
      sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
      mono24  = stereo ? sum_adj[SAMPLE_W:1] : wide_l;

      if (bad) begin
         cmd.kind   = KIND_ERROR;
         cmd.sample = '0;
      end else begin
         cmd.kind   = (native_rate_hz == OUT_RATE) ? KIND_PASS : KIND_SAMPLE;
         cmd.sample = mono24[SAMPLE_W-1:SAMPLE_W-MONO_W];
      end
   end

endmodule

[hdl/pdmr_back.sv]
// back part: resampling sequencer, phase state and result credits
module pdmr_back #(
   parameter int OUTPUT_RATE_HZ = pdmr_pkg::OUTPUT_RATE_DEFAULT,
   parameter int OUT_DEPTH      = pdmr_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [pdmr_pkg::RATE_W-1:0]             native_rate_hz,
   input  logic                                    cmd_empty,
   input  pdmr_pkg::pdmr_cmd_type                  cmd,
   output logic                                    cmd_pop,
   input  logic                                    out_pop,
   output pdmr_pkg::pdmr_ctl_type                  issue_ctl,
   output logic signed [pdmr_pkg::MONO_W-1:0]      issue_a,
   output logic signed [pdmr_pkg::MONO_W:0]        issue_diff,
   output logic [$clog2(OUTPUT_RATE_HZ)-1:0]       issue_frac
);

   import pdmr_pkg::*;

   localparam int FRAC_W    = $clog2(OUTPUT_RATE_HZ);
   localparam int ACC_W     = $clog2(OUTPUT_RATE_HZ + MAX_NATIVE_RATE);
   localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
   localparam int HALF_RATE = (OUTPUT_RATE_HZ + 1) / 2;
   localparam int LOW_RATE  = (HALF_RATE > MIN_NATIVE_RATE) ? HALF_RATE : MIN_NATIVE_RATE;

   localparam logic [RATE_W-1:0]   RATE_LO = RATE_W'(LOW_RATE);
   localparam logic [RATE_W-1:0]   RATE_HI = RATE_W'(MAX_NATIVE_RATE);
   localparam logic [ACC_W-1:0]    O_ACC   = ACC_W'(OUTPUT_RATE_HZ);

   logic signed [MONO_W-1:0] prev_ff, prev_in;
   logic                     have_prev_ff, have_prev_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [CREDIT_W-1:0]      credit_ff, credit_in;

   logic [RATE_W-1:0] rate;
   logic [ACC_W-1:0]  acc_add;
   logic              can_issue, acc_lt, add_wraps;

   always_comb begin
      if (native_rate_hz < RATE_LO) begin
         rate = RATE_LO;
      end else if (native_rate_hz > RATE_HI) begin
         rate = RATE_HI;
      end else begin
         rate = native_rate_hz;
      end

      acc_add   = acc_ff + ACC_W'(rate);
      acc_lt    = (acc_ff < O_ACC);
      add_wraps = (acc_add >= O_ACC);
      can_issue = (credit_ff < CREDIT_W'(OUT_DEPTH));

      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      acc_in       = acc_ff;
      cmd_pop      = 1'b0;
      issue_ctl    = '0;
      issue_a      = prev_ff;
      issue_diff   = {cmd.sample[MONO_W-1], cmd.sample} - {prev_ff[MONO_W-1], prev_ff};
      issue_frac   = acc_ff[FRAC_W-1:0];

      if (!cmd_empty) begin
         case (cmd.kind)
            KIND_ERROR: begin
               if (can_issue) begin
                  issue_ctl = '{valid: 1'b1, direct: 1'b1, err: 1'b1, last: 1'b1};
                  issue_a   = '0;
                  cmd_pop   = 1'b1;
               end
            end
            KIND_PASS: begin
               if (can_issue) begin
                  issue_ctl    = '{valid: 1'b1, direct: 1'b1, err: 1'b0, last: 1'b1};
                  issue_a      = cmd.sample;
                  prev_in      = '0;
                  have_prev_in = 1'b0;
                  acc_in       = '0;
                  cmd_pop      = 1'b1;
               end
            end
            KIND_SAMPLE: begin
               if (!have_prev_ff) begin
                  prev_in      = cmd.sample;
                  have_prev_in = 1'b1;
                  cmd_pop      = 1'b1;
               end else if (!acc_lt) begin
                  // still skipping native samples
                  acc_in  = acc_ff - O_ACC;
                  prev_in = cmd.sample;
                  cmd_pop = 1'b1;
               end else if (can_issue) begin
                  issue_ctl = '{valid: 1'b1, direct: 1'b0, err: 1'b0, last: add_wraps};
                  if (add_wraps) begin
                     acc_in  = acc_add - O_ACC;
                     prev_in = cmd.sample;
                     cmd_pop = 1'b1;
                  end else begin
                     acc_in = acc_add;
                  end
               end
            end
            default: begin
               cmd_pop = 1'b1;
            end
         endcase
      end

      credit_in = credit_ff + CREDIT_W'(issue_ctl.valid) - CREDIT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         acc_ff       <= '0;
         credit_ff    <= '0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         acc_ff       <= acc_in;
         credit_ff    <= credit_in;
      end
   end

endmodule

[hdl/pdmr_interp.sv]
// four-stage interpolation pipeline with rounding divide and clamp
module pdmr_interp #(
   parameter int OUTPUT_RATE_HZ = pdmr_pkg::OUTPUT_RATE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pdmr_pkg::pdmr_ctl_type               in_ctl,
   input  logic signed [pdmr_pkg::MONO_W-1:0]   in_a,
   input  logic signed [pdmr_pkg::MONO_W:0]     in_diff,
   input  logic [$clog2(OUTPUT_RATE_HZ)-1:0]    in_frac,
   output logic                                 out_push,
   output pdmr_pkg::pdmr_result_type            out_result
);

   import pdmr_pkg::*;

   localparam int     FRAC_W  = $clog2(OUTPUT_RATE_HZ);
   localparam longint O_L     = longint'(OUTPUT_RATE_HZ);
   localparam longint NUM_MAX = longint'(32768) * O_L;
   localparam int     NUM_W   = $clog2(NUM_MAX) + 2;
   localparam longint Y_MAX   = 2 * NUM_MAX + O_L;
   localparam int     Y_W     = $clog2(Y_MAX + 1);
   localparam longint D_L     = 2 * O_L;
   localparam longint K_L     = (longint'(1) << Y_W) / D_L;
   localparam int     Q_W     = $clog2(Y_MAX / D_L + 2);
   localparam int     P_W     = Y_W + Q_W;

   localparam logic signed [NUM_W-1:0] O_S       = NUM_W'(O_L);
   localparam logic [Y_W-1:0]          O_Y       = Y_W'(O_L);
   localparam logic [Y_W-1:0]          D_C       = Y_W'(D_L);
   localparam logic [P_W-1:0]          K_C       = P_W'(K_L);
   localparam logic [Q_W-1:0]          POS_LIMIT = Q_W'(S16_MAX);
   localparam logic [Q_W-1:0]          NEG_LIMIT = Q_W'(-S16_MIN);

   // stage 1: weighted sum
   logic signed [NUM_W-1:0]  a_ext, diff_ext, frac_ext;
   logic signed [NUM_W-1:0]  num1_ff, num1_in;
   pdmr_ctl_type             ctl1_ff;
   logic signed [MONO_W-1:0] a1_ff;

   // stage 2: magnitude and reciprocal multiply
   logic signed [NUM_W-1:0]  mag;
   logic [P_W-1:0]           prod;
   logic [Y_W-1:0]           y2_ff, y2_in;
   logic [Q_W-1:0]           q2_ff, q2_in;
   logic                     neg2_ff, neg2_in;
   pdmr_ctl_type             ctl2_ff;
   logic signed [MONO_W-1:0] a2_ff;

   // stage 3: quotient correction
   logic [Y_W-1:0]           rem;
   logic [Q_W-1:0]           q3_ff, q3_in;
   logic                     neg3_ff;
   pdmr_ctl_type             ctl3_ff;
   logic signed [MONO_W-1:0] a3_ff;

   // stage 4: sign, clamp and select
   logic [Q_W-1:0]           neg_q;
   logic                     valid4_ff;
   pdmr_result_type          res4_ff, res4_in;

   always_comb begin
      a_ext    = NUM_W'(in_a);
      diff_ext = NUM_W'(in_diff);
      frac_ext = $signed({{(NUM_W - FRAC_W){1'b0}}, in_frac});
      num1_in  = a_ext * O_S + diff_ext * frac_ext;
   end

   always_comb begin
      neg2_in = num1_ff[NUM_W-1];
      mag     = neg2_in ? -num1_ff : num1_ff;
      y2_in   = (Y_W'(mag) << 1) + O_Y;
      prod    = P_W'(y2_in) * K_C;
      q2_in   = prod[Y_W +: Q_W];
   end

   always_comb begin
      rem   = y2_ff - Y_W'(q2_ff) * D_C;
      q3_in = q2_ff + Q_W'(rem >= D_C);
   end

   always_comb begin
      neg_q        = -q3_ff;
      res4_in.err  = ctl3_ff.err;
      res4_in.last = ctl3_ff.last;
      if (ctl3_ff.direct) begin
         res4_in.sample = a3_ff;
      end else if (neg3_ff) begin
         res4_in.sample = (q3_ff > NEG_LIMIT) ? MONO_W'(S16_MIN) : neg_q[MONO_W-1:0];
      end else begin
         res4_in.sample = (q3_ff > POS_LIMIT) ? MONO_W'(S16_MAX) : q3_ff[MONO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff   <= '0;
         ctl2_ff   <= '0;
         ctl3_ff   <= '0;
         valid4_ff <= 1'b0;
      end else begin
         ctl1_ff   <= in_ctl;
         ctl2_ff   <= ctl1_ff;
         ctl3_ff   <= ctl2_ff;
         valid4_ff <= ctl3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      num1_ff <= num1_in;
      a1_ff   <= in_a;
      y2_ff   <= y2_in;
      q2_ff   <= q2_in;
      neg2_ff <= neg2_in;
      a2_ff   <= a1_ff;
      q3_ff   <= q3_in;
      neg3_ff <= neg2_ff;
      a3_ff   <= a2_ff;
      res4_ff <= res4_in;
   end

   assign out_push   = valid4_ff;
   assign out_result = res4_ff;

endmodule
